/* sv/assert_macros.svh */
// Assertion macros used by gyro_bias_calibrator_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define GBC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define GBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/gbc_pkg.sv */
// Package: types, constants and rounding helpers for the gyro bias calibrator.
`timescale 1ns / 1ps
package gbc_pkg;

  localparam int unsigned CALIB_SAMPLES_DEF = 200;
  localparam int unsigned SUM_W = 27;
  localparam int unsigned MAG_W = SUM_W - 1;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BYPASS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Z    = 3'd4;

  localparam logic [31:0] THRESHOLD_RST = 32'd839;
  localparam logic [15:0] GAIN_RST      = 16'd16384;

  typedef struct packed {
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] accel_y_flipped;
    logic               is_calibrated;
  } out_item_t;

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    if (v > 21'sd32767) begin
      return 16'sh7fff;
    end else if (v < -21'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Q2.14 product back to Q5.11: round half up, then saturate.
  function automatic logic signed [15:0] round_gain(input logic signed [33:0] p);
    logic signed [34:0] s;
    s = 35'(p) + 35'sd8192;
    return sat16($signed(s[34:14]));
  endfunction

endpackage

/* sv/gbc_in_if.sv */
// Input channel: one IMU frame per item.
`timescale 1ns / 1ps
interface gbc_in_if import gbc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* sv/gbc_out_if.sv */
// Output channel: one corrected frame per item.
`timescale 1ns / 1ps
interface gbc_out_if import gbc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* sv/gyro_bias_calibrator_top.sv */
// Gyro bias calibrator: stillness detection, bias averaging, flip and gain.
// One item per cycle while out_ch.ready does not stall the pipeline.
// Stages: input reg -> stillness/state update -> bias subtract and gain multiply -> round/sat.
// Bias mean comes from a constant-reciprocal multiply, loaded via the fin_go register after the completing frame.
// Reset (sync, active high) clears pipeline valids and calibration state, loads register defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gyro_bias_calibrator_top import gbc_pkg::*; #(
  parameter int unsigned CALIB_SAMPLES = CALIB_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  gbc_in_if.sink                in_ch,
  gbc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CNT_W  = $clog2(CALIB_SAMPLES + 1);
  localparam int unsigned DIV_L  = $clog2(CALIB_SAMPLES);
  localparam int unsigned DIV_SH = MAG_W + DIV_L;
  localparam int unsigned PROD_W = 2 * MAG_W + 1;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << DIV_SH) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES);
  localparam logic [MAG_W:0]   RECIP  = RECIP_FULL[MAG_W:0];
  localparam logic [MAG_W-1:0] HALF_N = MAG_W'(CALIB_SAMPLES / 2);
  localparam logic [CNT_W-1:0] N_CNT  = CNT_W'(CALIB_SAMPLES);

  // config registers
  logic        bypass;
  logic [31:0] threshold;
  logic [15:0] gain [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass    <= 1'b0;
      threshold <= THRESHOLD_RST;
      gain[0]   <= GAIN_RST;
      gain[1]   <= GAIN_RST;
      gain[2]   <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BYPASS:    bypass    <= cfg_data[0];
        REG_THRESHOLD: threshold <= cfg_data[31:0];
        REG_GAIN_X:    gain[0]   <= cfg_data[15:0];
        REG_GAIN_Y:    gain[1]   <= cfg_data[15:0];
        REG_GAIN_Z:    gain[2]   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4 = !v4 || out_ch.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ch.ready  = en1;
  assign out_ch.valid = v4;

  // stage 1: input register
  logic signed [15:0] g1 [3];
  logic signed [15:0] acc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_ch.valid) begin
      g1[0] <= in_ch.data.gyro_x;
      g1[1] <= in_ch.data.gyro_y;
      g1[2] <= in_ch.data.gyro_z;
      acc1  <= in_ch.data.accel_y;
    end
  end

  // calibration state
  logic signed [15:0]      prev [3];
  logic signed [SUM_W-1:0] bias_sum [3];
  logic signed [15:0]      bias [3];
  logic [CNT_W-1:0]        still_count;
  logic                    cal;
  logic                    fin_go;

  logic signed [16:0]      d [3];
  logic signed [33:0]      sq [3];
  logic [33:0]             dd;
  logic                    fresh;
  logic                    still;
  logic                    upd;
  logic                    done;
  logic [CNT_W-1:0]        cnt_inc;
  logic signed [SUM_W-1:0] sum_next [3];

  always_comb begin
    fresh = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d[i]        = {prev[i][15], prev[i]} - {g1[i][15], g1[i]};
      sq[i]       = d[i] * d[i];
      sum_next[i] = bias_sum[i] + {{(SUM_W-16){g1[i][15]}}, g1[i]};
      if (d[i] != 17'sd0) begin
        fresh = 1'b1;
      end
    end
    dd      = {2'b00, sq[0][31:0]} + {2'b00, sq[1][31:0]} + {2'b00, sq[2][31:0]};
    still   = dd < {2'b00, threshold};
    upd     = v1 && en2 && !bypass && !cal && fresh;
    cnt_inc = still_count + CNT_W'(1);
    done    = still && (cnt_inc >= N_CNT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        prev[i]     <= '0;
        bias_sum[i] <= '0;
      end
      still_count <= '0;
      cal         <= 1'b0;
      fin_go      <= 1'b0;
    end else begin
      fin_go <= 1'b0;
      if (upd) begin
        for (int i = 0; i < 3; i++) begin
          prev[i] <= g1[i];
        end
        if (still) begin
          // on completion the full sum stays here for the mean
          for (int i = 0; i < 3; i++) begin
            bias_sum[i] <= sum_next[i];
          end
          if (done) begin
            still_count <= '0;
            cal         <= 1'b1;
            fin_go      <= 1'b1;
          end else begin
            still_count <= cnt_inc;
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            bias_sum[i] <= '0;
          end
          still_count <= '0;
        end
      end
    end
  end

  // rounded mean: |sum| + N/2 times ceil(2^k / N), exact for |sum| + N/2 < 2^MAG_W
  logic                    neg [3];
  logic signed [SUM_W-1:0] neg_sum [3];
  logic [MAG_W-1:0]        mag [3];
  logic [PROD_W-1:0]       qprod [3];
  logic [16:0]             q [3];
  logic [16:0]             qs [3];
  logic signed [15:0]      bias_new [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg[i]      = bias_sum[i][SUM_W-1];
      neg_sum[i]  = -bias_sum[i];
      mag[i]      = (neg[i] ? neg_sum[i][MAG_W-1:0] : bias_sum[i][MAG_W-1:0]) + HALF_N;
      qprod[i]    = PROD_W'(mag[i]) * PROD_W'(RECIP);
      q[i]        = 17'(qprod[i] >> DIV_SH);
      qs[i]       = neg[i] ? -q[i] : q[i];
      bias_new[i] = qs[i][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        bias[i] <= '0;
      end
    end else if (fin_go) begin
      for (int i = 0; i < 3; i++) begin
        bias[i] <= bias_new[i];
      end
    end
  end

  // stage 2: after state update
  logic signed [15:0] g2 [3];
  logic signed [15:0] acc2;
  logic               byp2;
  logic               calb2;
  logic               cal2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      g2    <= g1;
      acc2  <= acc1;
      byp2  <= bypass;
      calb2 <= cal;
      cal2  <= cal || (upd && still && done);
    end
  end

  // stage 3: bias removal, z-axis and accel_y flip, gain multiply
  logic signed [15:0] bsel [3];
  logic signed [16:0] corr [3];
  logic signed [16:0] gs [3];
  logic signed [33:0] prod [3];
  logic signed [15:0] acc_sel;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bsel[i] = calb2 ? bias[i] : 16'sd0;
      gs[i]   = {1'b0, gain[i]};
    end
    corr[0] = {g2[0][15], g2[0]} - {bsel[0][15], bsel[0]};
    corr[1] = {g2[1][15], g2[1]} - {bsel[1][15], bsel[1]};
    corr[2] = {bsel[2][15], bsel[2]} - {g2[2][15], g2[2]};
    for (int i = 0; i < 3; i++) begin
      prod[i] = corr[i] * gs[i];
    end
    if (byp2) begin
      acc_sel = acc2;
    end else if (acc2 == 16'sh8000) begin
      acc_sel = 16'sh7fff;
    end else begin
      acc_sel = -acc2;
    end
  end

  logic signed [33:0] p3 [3];
  logic signed [15:0] g3 [3];
  logic signed [15:0] acc3;
  logic               byp3;
  logic               cal3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      p3   <= prod;
      g3   <= g2;
      acc3 <= acc_sel;
      byp3 <= byp2;
      cal3 <= cal2;
    end
  end

  // output register: round and saturate
  out_item_t res_next;

  always_comb begin
    res_next.rate_x          = byp3 ? g3[0] : round_gain(p3[0]);
    res_next.rate_y          = byp3 ? g3[1] : round_gain(p3[1]);
    res_next.rate_z          = byp3 ? g3[2] : round_gain(p3[2]);
    res_next.accel_y_flipped = acc3;
    res_next.is_calibrated   = cal3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      out_ch.data <= res_next;
    end
  end

  `GBC_ASSERT(a_fin_sets_cal, clk, rst, !fin_go || cal, "bias load without calibrated flag")
  `GBC_ASSERT(a_cnt_range, clk, rst, still_count < N_CNT, "still count reached sample limit")
  `GBC_ASSERT_NEXT(a_cal_sticky, clk, rst, cal, cal && !fin_go, "calibration lost or bias reloaded")
  `GBC_ASSERT_NEXT(a_bypass_frozen, clk, rst, v1 && en2 && bypass, $stable(still_count) && $stable(cal), "state moved in bypass")

endmodule

/* test/tb_gyro_bias_calibrator_top.sv */
// Testbench for the gyro bias calibrator: queued IMU frames, results checked against a predictor.
`timescale 1ns / 1ps
module tb_gyro_bias_calibrator_top;
  import gbc_pkg::*;

  localparam int CALIB_N      = CALIB_SAMPLES_DEF;
  localparam int DRAIN_CYCLES = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gbc_in_if  in_ch ();
  gbc_out_if out_ch ();

  gyro_bias_calibrator_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t  frame_q [$];
  out_item_t rate_expect_q [$];
  out_item_t want_res;
  int        send_idle;
  int        recv_idle;
  int        err_n;
  int        res_n;
  int        last_g [3];
  int        cal_base [3];

  // predictor state and register copies
  logic               m_bypass;
  logic [31:0]        m_thresh;
  logic [15:0]        m_gain [3];
  logic signed [15:0] prev_g [3];
  int                 bias_acc [3];
  logic signed [15:0] bias_est [3];
  int                 still_n;
  logic               cal_done;

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] gain_scale(input longint v, input logic [15:0] g);
    longint p;
    p = v * longint'(g);
    return clip16((p + 8192) >>> 14);
  endfunction

  function automatic int mean_round(input int s);
    int mag;
    int q;
    mag = (s < 0) ? -s : s;
    q = (mag + CALIB_N / 2) / CALIB_N;
    return (s < 0) ? -q : q;
  endfunction

  function automatic out_item_t calib_step(input in_item_t f);
    out_item_t         r;
    longint            g [3];
    longint            corr [3];
    longint            d;
    longint unsigned   dd;
    logic              fresh;
    int                i;
    g[0] = $signed(f.gyro_x);
    g[1] = $signed(f.gyro_y);
    g[2] = $signed(f.gyro_z);
    if (m_bypass) begin
      r.rate_x = f.gyro_x;
      r.rate_y = f.gyro_y;
      r.rate_z = f.gyro_z;
      r.accel_y_flipped = f.accel_y;
      r.is_calibrated = cal_done;
      return r;
    end
    for (i = 0; i < 3; i++) corr[i] = g[i] - longint'(bias_est[i]);
    if (!cal_done) begin
      fresh = 1'b0;
      dd = 0;
      for (i = 0; i < 3; i++) begin
        d = longint'(prev_g[i]) - g[i];
        if (d != 0) fresh = 1'b1;
        dd += d * d;
      end
      if (fresh) begin
        for (i = 0; i < 3; i++) prev_g[i] = g[i][15:0];
        if (dd < 64'(m_thresh)) begin
          for (i = 0; i < 3; i++) bias_acc[i] += int'(g[i]);
          still_n++;
          if (still_n >= CALIB_N) begin
            for (i = 0; i < 3; i++) begin
              bias_est[i] = 16'(mean_round(bias_acc[i]));
              bias_acc[i] = 0;
            end
            still_n = 0;
            cal_done = 1'b1;
          end
        end else begin
          for (i = 0; i < 3; i++) bias_acc[i] = 0;
          still_n = 0;
        end
      end
    end
    corr[2] = -corr[2];
    r.rate_x = gain_scale(corr[0], m_gain[0]);
    r.rate_y = gain_scale(corr[1], m_gain[1]);
    r.rate_z = gain_scale(corr[2], m_gain[2]);
    r.accel_y_flipped = clip16(-longint'($signed(f.accel_y)));
    r.is_calibrated = cal_done;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR result %0d: %s", res_n, msg);
    err_n++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, $signed(got), $signed(want)));
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        rate_expect_q.push_back(calib_step(in_ch.data));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (frame_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= frame_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
      if (out_ch.valid && out_ch.ready) begin
        res_n++;
        if (rate_expect_q.size() == 0) begin
          report_mismatch("result with no frame pending");
        end else begin
          want_res = rate_expect_q.pop_front();
          check_field("rate_x", out_ch.data.rate_x, want_res.rate_x);
          check_field("rate_y", out_ch.data.rate_y, want_res.rate_y);
          check_field("rate_z", out_ch.data.rate_z, want_res.rate_z);
          check_field("accel_y_flipped", out_ch.data.accel_y_flipped,
                      want_res.accel_y_flipped);
          check_field("is_calibrated", 16'(out_ch.data.is_calibrated),
                      16'(want_res.is_calibrated));
        end
      end
    end
  end

  function automatic int rnd_span(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int pick16();
    case ($urandom_range(9))
      0: return 32767;
      1: return -32768;
      default: return rnd_span(-32768, 32767);
    endcase
  endfunction

  function automatic int flip(input int v);
    return $urandom_range(1) ? v : -v;
  endfunction

  task automatic push_frame(input int gx, input int gy, input int gz, input int ay);
    in_item_t f;
    f.gyro_x  = 16'(gx);
    f.gyro_y  = 16'(gy);
    f.gyro_z  = 16'(gz);
    f.accel_y = 16'(ay);
    frame_q.push_back(f);
    last_g[0] = $signed(f.gyro_x);
    last_g[1] = $signed(f.gyro_y);
    last_g[2] = $signed(f.gyro_z);
  endtask

  task automatic repeat_frame();
    push_frame(last_g[0], last_g[1], last_g[2], pick16());
  endtask

  // forces a moving frame: 16384 LSB jump on every axis
  task automatic break_run();
    push_frame(last_g[0] ^ 32'h4000, last_g[1] ^ 32'h4000, last_g[2] ^ 32'h4000, pick16());
  endtask

  task automatic push_step(input int a, input int b, input int c);
    int v [3];
    int r;
    v[0] = a;
    v[1] = b;
    v[2] = c;
    r = $urandom_range(2);
    push_frame(last_g[0] + flip(v[r]), last_g[1] + flip(v[(r + 1) % 3]),
               last_g[2] + flip(v[(r + 2) % 3]), pick16());
  endtask

  task automatic wait_drained();
    while (frame_q.size() != 0 || in_ch.valid || rate_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BYPASS:    m_bypass = val[0];
      REG_THRESHOLD: m_thresh = val;
      REG_GAIN_X:    m_gain[0] = val[15:0];
      REG_GAIN_Y:    m_gain[1] = val[15:0];
      REG_GAIN_Z:    m_gain[2] = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_gains(input logic [15:0] gx, input logic [15:0] gy,
                           input logic [15:0] gz);
    write_reg(REG_GAIN_X, 32'(gx));
    write_reg(REG_GAIN_Y, 32'(gy));
    write_reg(REG_GAIN_Z, 32'(gz));
  endtask

  // still runs with random content, broken by moves; edge_steps only with threshold 100
  task automatic still_mix(input int n_items, input int k, input bit edge_steps,
                           input int max_run);
    int done;
    int run;
    int sel;
    int j;
    done = 0;
    while (done < n_items) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        run = ($urandom_range(9) == 0) ? rnd_span(max_run / 2, max_run) : rnd_span(1, 30);
        if (edge_steps && $urandom_range(1)) begin
          push_step(6, 8, 0);
        end else begin
          push_frame(rnd_span(-24000, 24000), rnd_span(-24000, 24000),
                     rnd_span(-24000, 24000), pick16());
        end
        for (j = 0; j < run; j++) begin
          sel = $urandom_range(99);
          if (sel < 12) begin
            repeat_frame();
          end else if (edge_steps && sel < 30) begin
            push_step(7, 7, 1);
          end else begin
            push_step($urandom_range(k), $urandom_range(k), $urandom_range(k));
          end
        end
        done += run + 1;
      end else if (sel < 90) begin
        push_frame(pick16(), pick16(), pick16(), pick16());
        done++;
      end else begin
        repeat_frame();
        done++;
      end
    end
  endtask

  task automatic cal_frames(input int n);
    int j;
    for (j = 0; j < n; j++) begin
      if ($urandom_range(1)) begin
        push_frame(pick16(), pick16(), pick16(), pick16());
      end else begin
        push_frame(rnd_span(cal_base[0] - 300, cal_base[0] + 300),
                   rnd_span(cal_base[1] - 300, cal_base[1] + 300),
                   rnd_span(cal_base[2] - 300, cal_base[2] + 300), pick16());
      end
    end
  endtask

  initial begin
    int i;
    int thr;
    int k;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    m_bypass = 1'b0;
    m_thresh = THRESHOLD_RST;
    for (i = 0; i < 3; i++) begin
      m_gain[i]   = GAIN_RST;
      prev_g[i]   = '0;
      bias_acc[i] = 0;
      bias_est[i] = '0;
      last_g[i]   = 0;
      cal_base[i] = 0;
    end
    still_n  = 0;
    cal_done = 1'b0;
    err_n    = 0;
    res_n    = 0;
    send_idle = 11;
    recv_idle = 66;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, flips, saturation, rounding ties, zero gain, bypass
    push_frame(0, 0, 0, 0);
    push_frame(32767, 32767, 32767, -32768);
    push_frame(-32768, -32768, -32768, 32767);
    push_frame(-32768, -32768, -32768, 0);
    push_frame(1, -1, 0, 1);
    push_frame(-1, 1, 1, -1);
    wait_drained();
    set_gains(16'd8192, 16'd8192, 16'd8192);
    push_frame(1, -1, 1, 0);
    push_frame(3, -3, -3, 0);
    push_frame(-3, 3, 3, 0);
    wait_drained();
    set_gains(16'hffff, 16'hffff, 16'hffff);
    push_frame(32767, -32768, 1, 0);
    push_frame(2, -2, -2, 32767);
    wait_drained();
    set_gains(16'd0, 16'd0, 16'd0);
    push_frame(12345, -32768, 32767, 5);
    wait_drained();
    write_reg(REG_BYPASS, 32'd1);
    push_frame(-32768, 32767, 100, -32768);
    push_frame(5, 6, 7, 8);
    wait_drained();
    write_reg(REG_BYPASS, 32'd0);
    set_gains(GAIN_RST, GAIN_RST, GAIN_RST);

    // uncalibrated: nothing still, then threshold edges, then a random threshold
    write_reg(REG_THRESHOLD, 32'd0);
    still_mix(30, 4, 1'b0, 40);
    wait_drained();
    write_reg(REG_THRESHOLD, 32'd100);
    still_mix(150, 5, 1'b1, 199);
    wait_drained();
    thr = rnd_span(4, 3000);
    k = int'($floor($sqrt((thr - 1) / 3.0)));
    write_reg(REG_THRESHOLD, 32'(thr));
    still_mix(120, k, 1'b0, 199);
    break_run();
    wait_drained();

    // full-scale jump must count as moving even though its square sum exceeds 32 bits
    send_idle = 66;
    recv_idle = 11;
    write_reg(REG_THRESHOLD, 32'hffff_ffff);
    for (i = 0; i < 104; i++)
      push_frame(32767 - rnd_span(0, 16), 32767 - rnd_span(0, 16), 32767 - rnd_span(0, 16),
                 pick16());
    push_frame(32767, 32767, 32767, pick16());
    push_frame(-32768, -32768, -32768, pick16());
    for (i = 0; i < 104; i++)
      push_frame(-32768 + rnd_span(0, 16), -32768 + rnd_span(0, 16),
                 -32768 + rnd_span(0, 16), pick16());
    wait_drained();
    write_reg(REG_THRESHOLD, 32'd100);
    break_run();
    wait_drained();

    // calibration: alternating frames put every axis mean on a half
    write_reg(REG_THRESHOLD, THRESHOLD_RST);
    break_run();
    for (i = 0; i < 3; i++) cal_base[i] = rnd_span(-24000, 24000);
    push_frame(cal_base[0], cal_base[1], cal_base[2], pick16());
    i = 1;
    while (i <= CALIB_N) begin
      if ($urandom_range(99) < 12) begin
        repeat_frame();
      end else begin
        if (i % 2) push_frame(cal_base[0] + 1, cal_base[1] - 1, cal_base[2] + 1, pick16());
        else push_frame(cal_base[0], cal_base[1], cal_base[2], pick16());
        i++;
      end
    end
    cal_frames(20);
    wait_drained();

    // calibrated
    send_idle = 0;
    recv_idle = 0;
    set_gains(16'($urandom), 16'($urandom), 16'($urandom));
    write_reg(REG_THRESHOLD, $urandom);
    cal_frames(50);
    wait_drained();
    set_gains(16'hffff, 16'd0, 16'd8192);
    cal_frames(40);
    wait_drained();
    write_reg(REG_BYPASS, 32'd1);
    cal_frames(30);
    wait_drained();
    write_reg(REG_BYPASS, 32'd0);
    write_reg(REG_THRESHOLD, 32'hffff_ffff);
    set_gains(GAIN_RST, GAIN_RST, GAIN_RST);
    cal_frames(40);
    wait_drained();
    set_gains(16'($urandom), 16'($urandom), 16'($urandom));
    cal_frames(40);
    wait_drained();

    if (err_n == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/gbc_pkg.sv
sv/gbc_in_if.sv
sv/gbc_out_if.sv
sv/gyro_bias_calibrator_top.sv
test/tb_gyro_bias_calibrator_top.sv
